[hw/rtl/source_token_scanner_macros.svh]
// ----------------------------------------------------------------------------
// source_token_scanner assertion macros
// shared shorthand for clocked checks on aclk with aresetn low disabling them
// ----------------------------------------------------------------------------
`ifndef SOURCE_TOKEN_SCANNER_MACROS_SVH
`define SOURCE_TOKEN_SCANNER_MACROS_SVH

// condition must never hold
`define STC_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define STC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

[hw/rtl/stc_pkg.sv]
// ----------------------------------------------------------------------------
// stc_pkg
// types, token kinds and keyword table of the source token scanner
// ----------------------------------------------------------------------------
`default_nettype none

package stc_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int LINE_BITS_DEF     = 16;
    localparam int QUEUE_DEPTH       = 4;
    localparam int GROUP_MAX         = 3;

    localparam logic [5:0] KIND_LPAREN  = 6'd0;
    localparam logic [5:0] KIND_RPAREN  = 6'd1;
    localparam logic [5:0] KIND_LBRACE  = 6'd2;
    localparam logic [5:0] KIND_RBRACE  = 6'd3;
    localparam logic [5:0] KIND_COMMA   = 6'd4;
    localparam logic [5:0] KIND_DOT     = 6'd5;
    localparam logic [5:0] KIND_MINUS   = 6'd6;
    localparam logic [5:0] KIND_PLUS    = 6'd7;
    localparam logic [5:0] KIND_SEMI    = 6'd8;
    localparam logic [5:0] KIND_SLASH   = 6'd9;
    localparam logic [5:0] KIND_STAR    = 6'd10;
    localparam logic [5:0] KIND_BANG    = 6'd11;
    localparam logic [5:0] KIND_ASSIGN  = 6'd13;
    localparam logic [5:0] KIND_GREATER = 6'd15;
    localparam logic [5:0] KIND_LESS    = 6'd17;
    localparam logic [5:0] KIND_IDENT   = 6'd19;
    localparam logic [5:0] KIND_STRING  = 6'd20;
    localparam logic [5:0] KIND_NUMBER  = 6'd21;
    localparam logic [5:0] KIND_KW_BASE = 6'd22;
    localparam logic [5:0] KIND_ERROR   = 6'd36;
    localparam logic [5:0] KIND_EOF     = 6'd37;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
    localparam logic [1:0] ERR_UNTERM_STR = 2'd2;

    localparam int NUM_KEYWORDS = 14;

    typedef struct packed {
        logic [1:0]  error_code;
        logic [15:0] line;
        logic [15:0] length;
        logic [15:0] start_offset;
        logic [5:0]  kind;
    } tok_t;

    typedef struct packed {
        logic [1:0]           cnt;
        tok_t [GROUP_MAX-1:0] tok;
    } group_t;

    // keyword spelling, first byte in the low bits
    function automatic logic [47:0] kw_word(input int idx);
        logic [47:0] w;
        case (idx)
            0:       w = 48'("dna");
            1:       w = 48'("ssalc");
            2:       w = 48'("esle");
            3:       w = 48'("eslaf");
            4:       w = 48'("rof");
            5:       w = 48'("nf");
            6:       w = 48'("fi");
            7:       w = 48'("llun");
            8:       w = 48'("ro");
            9:       w = 48'("tnirp");
            10:      w = 48'("nruter");
            11:      w = 48'("repus");
            12:      w = 48'("rav");
            13:      w = 48'("elihw");
            default: w = '1;
        endcase
        return w;
    endfunction

    function automatic logic [5:0] ident_kind(input logic [47:0] prefix, input logic short_ok);
        logic [5:0] k;
        k = KIND_IDENT;
        for (int i = 0; i < NUM_KEYWORDS; i++) begin
            if (short_ok && prefix == kw_word(i)) begin
                k = 6'(KIND_KW_BASE + 6'(i));
            end
        end
        return k;
    endfunction

    function automatic logic [5:0] op_kind(input logic [7:0] c, input logic with_eq);
        logic [5:0] k;
        k = (c == "!") ? KIND_BANG : (c == "=") ? KIND_ASSIGN :
            (c == ">") ? KIND_GREATER : KIND_LESS;
        return with_eq ? 6'(k + 6'd1) : k;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/source_token_scanner.sv]
// ----------------------------------------------------------------------------
// source_token_scanner
// one-pass lexical scanner: source bytes in, tokens out
// ----------------------------------------------------------------------------
// One source byte is taken per cycle (s_tlast marks the final byte) and each
// byte is scanned in the cycle it is accepted, so input runs at one item per
// clock. A byte yields zero to three tokens; they wait as one group in a
// four-entry queue and leave one token per cycle while m_tready is high,
// m_tlast marking the last token caused by that byte. Output is therefore
// bounded by the single token port: a byte that yields several tokens sends
// them over it one after another, and the input stalls only when the queue is
// full. After the final byte the scanner is back at position 0, line 1.
`default_nettype none

`include "source_token_scanner_macros.svh"

module source_token_scanner import stc_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int LINE_BITS     = LINE_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // ch[7:0]
    input  wire logic        s_tlast,   // end_of_source
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // kind[5:0] start_offset[21:6] length[37:22]
                                        // line[53:38] error_code[55:54]
    output logic             m_tlast    // last_of_run
);

    group_t fr_grp, head_grp;
    logic   fr_valid, full, head_valid, pop, s_fire;
    tok_t   out_tok;

    assign s_tready = !full;
    assign s_fire   = s_tvalid && s_tready;

    stc_front #(
        .POSITION_BITS (POSITION_BITS),
        .LINE_BITS     (LINE_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (s_fire),
        .ch        (s_tdata),
        .eos       (s_tlast),
        .grp       (fr_grp),
        .grp_valid (fr_valid)
    );

    stc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (fr_valid),
        .push_grp   (fr_grp),
        .pop        (pop),
        .head_grp   (head_grp),
        .head_valid (head_valid),
        .full       (full)
    );

    stc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_grp   (head_grp),
        .head_valid (head_valid),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_tok    (out_tok),
        .out_last   (m_tlast),
        .out_ready  (m_tready)
    );

    assign m_tdata = out_tok;

    `STC_ASSERT_NEVER(a_kind_range, m_tvalid && (m_tdata[5:0] > KIND_EOF), "kind out of range")
    `STC_ASSERT_IMPL(a_err_kind, m_tvalid && (m_tdata[55:54] != ERR_NONE),
                     m_tdata[5:0] == KIND_ERROR, "error code on non-error token")
    `STC_ASSERT_IMPL(a_empty_group, head_valid, head_grp.cnt != 2'd0, "empty group queued")
    `STC_ASSERT_NEVER(a_push_full, fr_valid && full, "push into full queue")

endmodule

`default_nettype wire

[hw/rtl/stc_front.sv]
// ----------------------------------------------------------------------------
// stc_front
// byte classifier and scan state; turns each byte into a group of tokens
// ----------------------------------------------------------------------------
`default_nettype none

module stc_front import stc_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int LINE_BITS     = LINE_BITS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       fire,
    input  wire logic [7:0] ch,
    input  wire logic       eos,
    output group_t          grp,
    output logic            grp_valid
);

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_NUM_DOT, M_FRACTION, M_OP, M_SLASH, M_COMMENT, M_STRING
    } mode_t;

    localparam int NCAND = 6;

    mode_t                    mode_reg, mode_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next, start_reg, start_next;
    logic [LINE_BITS-1:0]     line_reg, line_next, line_mid;
    logic [7:0]               held_reg, held_next;
    logic [47:0]              prefix_reg, prefix_next;
    logic                     brace_reg, brace_next;

    logic [POSITION_BITS-1:0] len, len2, len_m1, len2_m1, pos_adv;
    logic                     nl, restart, is_dig, is_alp;
    logic [15:0]              line_pre, line_post;
    tok_t [NCAND-1:0]         cand;
    logic [NCAND-1:0]         cv;
    logic [2:0]               k;

    function automatic logic [15:0] sat16(input logic [32:0] v);
        return (v > 33'h0FFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [15:0] lo16(input logic [31:0] v);
        return v[15:0];
    endfunction

    function automatic tok_t mk(input logic [5:0] kd, input logic [31:0] st,
                                input logic [32:0] ln, input logic [15:0] li,
                                input logic [1:0] er);
        tok_t t;
        t.kind         = kd;
        t.start_offset = lo16(st);
        t.length       = sat16(ln);
        t.line         = li;
        t.error_code   = er;
        return t;
    endfunction

    always_comb begin
        mode_next   = mode_reg;
        start_next  = start_reg;
        held_next   = held_reg;
        prefix_next = prefix_reg;
        brace_next  = brace_reg;
        nl          = 1'b0;
        restart     = 1'b0;
        cand        = '0;
        cv          = '0;

        is_dig  = (ch >= "0") && (ch <= "9");
        is_alp  = ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z")) || (ch == "_");
        pos_adv = (pos_reg == '1) ? pos_reg : pos_reg + 1'b1;
        len     = pos_reg - start_reg;
        // a saturated position can leave the number with no length
        len_m1  = (len == '0) ? '0 : len - 1'b1;
        line_pre = sat16(33'(line_reg));

        unique case (mode_reg)
            M_IDENT: begin
                if (is_alp || is_dig) begin
                    if (len < POSITION_BITS'(6)) begin
                        prefix_next = prefix_reg | (48'(ch) << (6'(len[2:0]) * 6'd8));
                    end
                end else begin
                    cand[0] = mk(ident_kind(prefix_reg, (len != '0) && (len <= POSITION_BITS'(6))),
                                 32'(start_reg), 33'(len), line_pre, ERR_NONE);
                    cv[0]   = 1'b1;
                    restart = 1'b1;
                end
            end
            M_NUMBER, M_FRACTION: begin
                if (!is_dig) begin
                    if (ch == "." && mode_reg == M_NUMBER) begin
                        mode_next = M_NUM_DOT;
                    end else begin
                        cand[0] = mk(KIND_NUMBER, 32'(start_reg), 33'(len), line_pre, ERR_NONE);
                        cv[0]   = 1'b1;
                        restart = 1'b1;
                    end
                end
            end
            M_NUM_DOT: begin
                if (is_dig) begin
                    mode_next = M_FRACTION;
                end else begin
                    // digits before the dot, then the dot on its own
                    cand[0] = mk(KIND_NUMBER, 32'(start_reg), 33'(len_m1), line_pre, ERR_NONE);
                    cand[1] = mk(KIND_DOT, 32'(start_reg) + 32'(len_m1), 33'd1, line_pre,
                                 ERR_NONE);
                    cv[1:0] = 2'b11;
                    restart = 1'b1;
                end
            end
            M_OP: begin
                if (ch == "=") begin
                    cand[0]   = mk(op_kind(held_reg, 1'b1), 32'(start_reg), 33'(len) + 33'd1,
                                   line_pre, ERR_NONE);
                    cv[0]     = 1'b1;
                    mode_next = M_IDLE;
                end else begin
                    cand[0] = mk(op_kind(held_reg, 1'b0), 32'(start_reg), 33'(len), line_pre,
                                 ERR_NONE);
                    cv[0]   = 1'b1;
                    restart = 1'b1;
                end
            end
            M_SLASH: begin
                if (ch == "/") begin
                    mode_next = M_COMMENT;
                end else begin
                    cand[0] = mk(KIND_SLASH, 32'(start_reg), 33'(len), line_pre, ERR_NONE);
                    cv[0]   = 1'b1;
                    restart = 1'b1;
                end
            end
            M_COMMENT: begin
                if (ch == "\n") begin
                    nl        = 1'b1;
                    mode_next = M_IDLE;
                end
            end
            M_STRING: begin
                nl = (ch == "\n");
                if (brace_reg) begin
                    if (ch == "}") begin
                        brace_next = 1'b0;
                    end
                end else if (ch == "\"") begin
                    cand[0]   = mk(KIND_STRING, 32'(start_reg), 33'(len) + 33'd1, line_pre,
                                   ERR_NONE);
                    cv[0]     = 1'b1;
                    mode_next = M_IDLE;
                end else if (ch == "{") begin
                    brace_next = 1'b1;
                end
            end
            default: begin
                restart = 1'b1;
            end
        endcase

        if (restart) begin
            mode_next  = M_IDLE;
            start_next = pos_reg;
            cv[2]      = 1'b1;
            case (ch)
                " ", "\r", "\t": cv[2] = 1'b0;
                "\n": begin
                    nl    = 1'b1;
                    cv[2] = 1'b0;
                end
                "(": cand[2] = mk(KIND_LPAREN, 32'(pos_reg), 33'd1, line_pre, ERR_NONE);
                ")": cand[2] = mk(KIND_RPAREN, 32'(pos_reg), 33'd1, line_pre, ERR_NONE);
                "{": cand[2] = mk(KIND_LBRACE, 32'(pos_reg), 33'd1, line_pre, ERR_NONE);
                "}": cand[2] = mk(KIND_RBRACE, 32'(pos_reg), 33'd1, line_pre, ERR_NONE);
                ",": cand[2] = mk(KIND_COMMA, 32'(pos_reg), 33'd1, line_pre, ERR_NONE);
                ".": cand[2] = mk(KIND_DOT, 32'(pos_reg), 33'd1, line_pre, ERR_NONE);
                "-": cand[2] = mk(KIND_MINUS, 32'(pos_reg), 33'd1, line_pre, ERR_NONE);
                "+": cand[2] = mk(KIND_PLUS, 32'(pos_reg), 33'd1, line_pre, ERR_NONE);
                ";": cand[2] = mk(KIND_SEMI, 32'(pos_reg), 33'd1, line_pre, ERR_NONE);
                "*": cand[2] = mk(KIND_STAR, 32'(pos_reg), 33'd1, line_pre, ERR_NONE);
                "/": begin
                    mode_next = M_SLASH;
                    cv[2]     = 1'b0;
                end
                "!", "=", "<", ">": begin
                    held_next = ch;
                    mode_next = M_OP;
                    cv[2]     = 1'b0;
                end
                "\"": begin
                    brace_next = 1'b0;
                    mode_next  = M_STRING;
                    cv[2]      = 1'b0;
                end
                default: begin
                    if (is_alp) begin
                        prefix_next = 48'(ch);
                        mode_next   = M_IDENT;
                        cv[2]       = 1'b0;
                    end else if (is_dig) begin
                        mode_next = M_NUMBER;
                        cv[2]     = 1'b0;
                    end else begin
                        cand[2] = mk(KIND_ERROR, 32'(pos_reg), 33'd1, line_pre, ERR_UNEXPECTED);
                    end
                end
            endcase
        end

        line_mid  = (nl && line_reg != '1) ? line_reg + 1'b1 : line_reg;
        line_post = sat16(33'(line_mid));
        len2      = pos_adv - start_next;
        len2_m1   = (len2 == '0) ? '0 : len2 - 1'b1;

        // close whatever is open at the end of the source
        if (eos) begin
            unique case (mode_next)
                M_IDENT: begin
                    cand[3] = mk(ident_kind(prefix_next,
                                            (len2 != '0) && (len2 <= POSITION_BITS'(6))),
                                 32'(start_next), 33'(len2), line_post, ERR_NONE);
                    cv[3]   = 1'b1;
                end
                M_NUMBER, M_FRACTION: begin
                    cand[3] = mk(KIND_NUMBER, 32'(start_next), 33'(len2), line_post, ERR_NONE);
                    cv[3]   = 1'b1;
                end
                M_NUM_DOT: begin
                    cand[3] = mk(KIND_NUMBER, 32'(start_next), 33'(len2_m1), line_post,
                                 ERR_NONE);
                    cand[4] = mk(KIND_DOT, 32'(start_next) + 32'(len2_m1), 33'd1,
                                 line_post, ERR_NONE);
                    cv[4:3] = 2'b11;
                end
                M_OP: begin
                    cand[3] = mk(op_kind(held_next, 1'b0), 32'(start_next), 33'(len2),
                                 line_post, ERR_NONE);
                    cv[3]   = 1'b1;
                end
                M_SLASH: begin
                    cand[3] = mk(KIND_SLASH, 32'(start_next), 33'(len2), line_post, ERR_NONE);
                    cv[3]   = 1'b1;
                end
                M_STRING: begin
                    cand[3] = mk(KIND_ERROR, 32'(start_next), 33'(len2), line_post,
                                 ERR_UNTERM_STR);
                    cv[3]   = 1'b1;
                end
                default: ;
            endcase
            cand[5] = mk(KIND_EOF, 32'(pos_adv), 33'd0, line_post, ERR_NONE);
            cv[5]   = ($countones(cv[4:0]) < 3);
        end

        // pack the valid candidates in order, at most three
        grp = '0;
        k   = '0;
        for (int i = 0; i < NCAND; i++) begin
            if (cv[i] && k < 3'd3) begin
                grp.tok[k[1:0]] = cand[i];
                k = k + 3'd1;
            end
        end
        grp.cnt   = k[1:0];
        grp_valid = fire && (k != 3'd0);

        line_next = line_mid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= M_IDLE;
            pos_reg    <= '0;
            line_reg   <= LINE_BITS'(1);
            start_reg  <= '0;
            held_reg   <= '0;
            prefix_reg <= '0;
            brace_reg  <= 1'b0;
        end else if (fire) begin
            if (eos) begin
                mode_reg   <= M_IDLE;
                pos_reg    <= '0;
                line_reg   <= LINE_BITS'(1);
                start_reg  <= '0;
                held_reg   <= '0;
                prefix_reg <= '0;
                brace_reg  <= 1'b0;
            end else begin
                mode_reg   <= mode_next;
                pos_reg    <= pos_adv;
                line_reg   <= line_next;
                start_reg  <= start_next;
                held_reg   <= held_next;
                prefix_reg <= prefix_next;
                brace_reg  <= brace_next;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/stc_queue.sv]
// ----------------------------------------------------------------------------
// stc_queue
// short queue of token groups between scanner and output sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module stc_queue import stc_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire group_t push_grp,
    input  wire logic   pop,
    output group_t      head_grp,
    output logic        head_valid,
    output logic        full
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    group_t                entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_reg, rd_reg;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;

    assign head_grp   = entry_reg[rd_reg];
    assign head_valid = (cnt_reg != '0);
    assign full       = (cnt_reg == CNT_BITS'(QUEUE_DEPTH));

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_reg] <= push_grp;
        end
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/stc_back.sv]
// ----------------------------------------------------------------------------
// stc_back
// output sequencer; sends the tokens of each queued group one per item
// ----------------------------------------------------------------------------
`default_nettype none

module stc_back import stc_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire group_t head_grp,
    input  wire logic   head_valid,
    output logic        pop,
    output logic        out_valid,
    output tok_t        out_tok,
    output logic        out_last,
    input  wire logic   out_ready
);

    logic [1:0] idx_reg;
    logic       fire;

    assign out_valid = head_valid;
    assign out_tok   = head_grp.tok[idx_reg];
    assign out_last  = (idx_reg == head_grp.cnt - 2'd1);
    assign fire      = out_valid && out_ready;
    assign pop       = fire && out_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (fire) begin
            idx_reg <= out_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

endmodule

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench for source_token_scanner
// drives source bytes through the scanner and checks every token it produces
// against a cycle-free predictor of the scanning rules, with random idling
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import stc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {
        SC_IDLE, SC_IDENT, SC_NUMBER, SC_NUM_DOT, SC_FRACTION,
        SC_OP, SC_SLASH, SC_COMMENT, SC_STRING
    } scan_e;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } src_byte_t;

    typedef struct {
        logic [5:0]  kind;
        logic [15:0] start_offset;
        logic [15:0] length;
        logic [15:0] line;
        logic [1:0]  error_code;
        logic        last;
    } token_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // ch[7:0]
    logic        s_tlast;     // end_of_source
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;     // kind[5:0] start_offset[21:6] length[37:22]
                              // line[53:38] error_code[55:54]
    logic        m_tlast;     // last_of_run

    source_token_scanner u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    src_byte_t source_q[$];
    token_t    token_q[$];
    int        mismatches   = 0;
    int        bytes_sent   = 0;
    int        tokens_seen  = 0;
    int        sources_done = 0;
    int        cycle_count  = 0;
    int        hold_at      = 60;
    bit        hold_done    = 0;
    int        src_gap      = 0;
    int        sink_gap     = 0;
    bit        quiet_tail   = 0;

    // scanner state as predicted
    scan_e       sc_mode;
    logic [15:0] sc_pos;
    logic [15:0] sc_line;
    logic [15:0] sc_start;
    logic [7:0]  sc_held;
    logic [47:0] sc_prefix;
    bit          sc_in_brace;
    token_t      grp[4];
    int          grp_n;

    string kw_names[14] = '{"and", "class", "else", "false", "for", "fn", "if",
                            "null", "or", "print", "return", "super", "var", "while"};

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void scanner_clear();
        sc_mode     = SC_IDLE;
        sc_pos      = '0;
        sc_line     = 16'd1;
        sc_start    = '0;
        sc_held     = '0;
        sc_prefix   = '0;
        sc_in_brace = 0;
    endfunction

    function automatic void emit(logic [5:0] k, int unsigned st, int unsigned len,
                                 logic [1:0] err);
        if (grp_n >= 4) return;
        grp[grp_n].kind         = k;
        grp[grp_n].start_offset = st[15:0];
        grp[grp_n].length       = len > 65535 ? 16'hffff : len[15:0];
        grp[grp_n].line         = sc_line;
        grp[grp_n].error_code   = err;
        grp[grp_n].last         = 0;
        grp_n++;
    endfunction

    function automatic void bump_line();
        if (sc_line != 16'hffff) sc_line++;
    endfunction

    function automatic logic [5:0] word_kind(int unsigned len);
        logic [47:0] w;
        if (len == 0 || len > 6) return KIND_IDENT;
        for (int i = 0; i < 14; i++) begin
            w = '0;
            for (int j = 0; j < kw_names[i].len(); j++)
                w |= 48'(kw_names[i][j]) << (8 * j);
            if (w == sc_prefix) return 6'(KIND_KW_BASE + i);
        end
        return KIND_IDENT;
    endfunction

    function automatic logic [5:0] relop_kind(logic [7:0] c, bit with_eq);
        logic [5:0] k;
        k = c == "!" ? KIND_BANG : c == "=" ? KIND_ASSIGN : c == ">" ? KIND_GREATER : KIND_LESS;
        return with_eq ? 6'(k + 1) : k;
    endfunction

    function automatic void close_num_dot(int unsigned len);
        int unsigned n;
        n = len > 0 ? len - 1 : 0;
        emit(KIND_NUMBER, sc_start, n, ERR_NONE);
        emit(KIND_DOT, sc_start + n, 1, ERR_NONE);
    endfunction

    function automatic void begin_token(logic [7:0] c, logic [15:0] p);
        sc_start = p;
        case (c)
            " ", "\r", "\t": ;
            "\n": bump_line();
            "(": emit(KIND_LPAREN, p, 1, ERR_NONE);
            ")": emit(KIND_RPAREN, p, 1, ERR_NONE);
            "{": emit(KIND_LBRACE, p, 1, ERR_NONE);
            "}": emit(KIND_RBRACE, p, 1, ERR_NONE);
            ",": emit(KIND_COMMA, p, 1, ERR_NONE);
            ".": emit(KIND_DOT, p, 1, ERR_NONE);
            "-": emit(KIND_MINUS, p, 1, ERR_NONE);
            "+": emit(KIND_PLUS, p, 1, ERR_NONE);
            ";": emit(KIND_SEMI, p, 1, ERR_NONE);
            "*": emit(KIND_STAR, p, 1, ERR_NONE);
            "/": sc_mode = SC_SLASH;
            "!", "=", "<", ">": begin
                sc_held = c;
                sc_mode = SC_OP;
            end
            "\"": begin
                sc_in_brace = 0;
                sc_mode     = SC_STRING;
            end
            default: begin
                if (is_letter(c)) begin
                    sc_prefix = 48'(c);
                    sc_mode   = SC_IDENT;
                end else if (is_num(c)) begin
                    sc_mode = SC_NUMBER;
                end else begin
                    emit(KIND_ERROR, p, 1, ERR_UNEXPECTED);
                end
            end
        endcase
    endfunction

    // returns 1 when the byte was consumed by the token in progress
    function automatic bit continue_token(logic [7:0] c, int unsigned len);
        case (sc_mode)
            SC_IDENT: begin
                if (is_letter(c) || is_num(c)) begin
                    if (len < 6) sc_prefix |= 48'(c) << (8 * len);
                    return 1;
                end
                emit(word_kind(len), sc_start, len, ERR_NONE);
            end
            SC_NUMBER: begin
                if (is_num(c)) return 1;
                if (c == ".") begin
                    sc_mode = SC_NUM_DOT;
                    return 1;
                end
                emit(KIND_NUMBER, sc_start, len, ERR_NONE);
            end
            SC_NUM_DOT: begin
                if (is_num(c)) begin
                    sc_mode = SC_FRACTION;
                    return 1;
                end
                close_num_dot(len);
            end
            SC_FRACTION: begin
                if (is_num(c)) return 1;
                emit(KIND_NUMBER, sc_start, len, ERR_NONE);
            end
            SC_OP: begin
                sc_mode = SC_IDLE;
                if (c == "=") begin
                    emit(relop_kind(sc_held, 1), sc_start, len + 1, ERR_NONE);
                    return 1;
                end
                emit(relop_kind(sc_held, 0), sc_start, len, ERR_NONE);
            end
            SC_SLASH: begin
                if (c == "/") begin
                    sc_mode = SC_COMMENT;
                    return 1;
                end
                emit(KIND_SLASH, sc_start, len, ERR_NONE);
            end
            SC_COMMENT: begin
                if (c == "\n") begin
                    bump_line();
                    sc_mode = SC_IDLE;
                end
                return 1;
            end
            SC_STRING: begin
                if (c == "\n") bump_line();
                if (sc_in_brace) begin
                    if (c == "}") sc_in_brace = 0;
                end else if (c == "\"") begin
                    emit(KIND_STRING, sc_start, len + 1, ERR_NONE);
                    sc_mode = SC_IDLE;
                end else if (c == "{") begin
                    sc_in_brace = 1;
                end
                return 1;
            end
            default: ;
        endcase
        return 0;
    endfunction

    function automatic void predict_tokens(logic [7:0] c, logic eos);
        int unsigned len;
        grp_n = 0;
        len   = sc_pos - sc_start;
        if (!continue_token(c, len)) begin
            sc_mode = SC_IDLE;
            begin_token(c, sc_pos);
        end
        if (sc_pos != 16'hffff) sc_pos++;
        if (eos) begin
            len = sc_pos - sc_start;
            case (sc_mode)
                SC_IDENT:               emit(word_kind(len), sc_start, len, ERR_NONE);
                SC_NUMBER, SC_FRACTION: emit(KIND_NUMBER, sc_start, len, ERR_NONE);
                SC_NUM_DOT:             close_num_dot(len);
                SC_OP:                  emit(relop_kind(sc_held, 0), sc_start, len, ERR_NONE);
                SC_SLASH:               emit(KIND_SLASH, sc_start, len, ERR_NONE);
                SC_STRING:              emit(KIND_ERROR, sc_start, len, ERR_UNTERM_STR);
                default: ;
            endcase
            if (grp_n < 3) emit(KIND_EOF, sc_pos, 0, ERR_NONE);
            scanner_clear();
        end
        if (grp_n > 3) grp_n = 3;
        if (grp_n > 0) grp[grp_n-1].last = 1;
        for (int i = 0; i < grp_n; i++) token_q.push_back(grp[i]);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("token %0d: %s got %0d expected %0d", tokens_seen, what, got, want);
        mismatches++;
    endtask

    function automatic void push_byte(logic [7:0] c);
        src_byte_t b;
        b.ch   = c;
        b.last = 0;
        source_q.push_back(b);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endfunction

    function automatic void end_source();
        source_q[$].last = 1;
    endfunction

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // one random token-shaped fragment, mostly well formed
    function automatic void push_fragment();
        int n;
        case ($urandom_range(0, 9))
            0, 1: push_text(kw_names[$urandom_range(0, 13)]);
            2: begin
                n = $urandom_range(1, 9);
                push_byte(pick("abcdefghijklmnopqrstuvwxyzABCXYZ_"));
                for (int i = 1; i < n; i++)
                    push_byte(pick("abcfilnorstuvwxyz_0123456789EZ"));
            end
            3: begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) push_byte(pick("0123456789"));
                if ($urandom_range(0, 1)) begin
                    push_byte(".");
                    n = $urandom_range(0, 3);
                    for (int i = 0; i < n; i++) push_byte(pick("0123456789"));
                end
            end
            4: begin
                push_byte(pick("!=<>"));
                if ($urandom_range(0, 1)) push_byte("=");
            end
            5: push_byte(pick("(){},.-+;*/"));
            6: begin
                push_byte("\"");
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++) push_byte(pick("ab {}\"\n x1"));
                if ($urandom_range(0, 4) != 0) push_byte("\"");
            end
            7: begin
                push_text("//");
                n = $urandom_range(0, 5);
                for (int i = 0; i < n; i++) push_byte(pick("ab/ \"{=x"));
                push_byte("\n");
            end
            default: push_byte(8'($urandom_range(0, 255)));
        endcase
        if ($urandom_range(0, 2) != 0) push_byte(pick("  \t\r\n"));
    endfunction

    // driver: one byte per handshake
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
            s_tdata  <= '0;
            s_tlast  <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_tokens(s_tdata, s_tlast);
                bytes_sent++;
                if (s_tlast) sources_done++;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 0;
                end else if (!hold_done && bytes_sent >= hold_at && token_q.size() != 0) begin
                    // wait here until every predicted token has come out
                    s_tvalid <= 0;
                end else if (source_q.size() == 0) begin
                    s_tvalid <= 0;
                end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                    src_gap  <= $urandom_range(0, 2);
                    s_tvalid <= 0;
                end else begin
                    if (bytes_sent >= hold_at) hold_done = 1;
                    s_tvalid <= 1;
                    s_tdata  <= source_q[0].ch;
                    s_tlast  <= source_q[0].last;
                    void'(source_q.pop_front());
                end
            end
        end
    end

    // monitor and result sink
    always @(posedge aclk) begin
        token_t want;
        if (!aresetn) begin
            m_tready <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (token_q.size() == 0) begin
                    $display("token %0d: unexpected token kind %0d", tokens_seen, m_tdata[5:0]);
                    mismatches++;
                end else begin
                    want = token_q.pop_front();
                    if (m_tdata[5:0] != want.kind)
                        report_mismatch("kind", m_tdata[5:0], want.kind);
                    if (m_tdata[21:6] != want.start_offset)
                        report_mismatch("start", m_tdata[21:6], want.start_offset);
                    if (m_tdata[37:22] != want.length)
                        report_mismatch("length", m_tdata[37:22], want.length);
                    if (m_tdata[53:38] != want.line)
                        report_mismatch("line", m_tdata[53:38], want.line);
                    if (m_tdata[55:54] != want.error_code)
                        report_mismatch("error", m_tdata[55:54], want.error_code);
                    if (m_tlast != want.last)
                        report_mismatch("tlast", m_tlast, want.last);
                end
                tokens_seen++;
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 0;
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                sink_gap <= $urandom_range(0, 2);
                m_tready <= 0;
            end else begin
                m_tready <= 1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > 100000) begin
            $display("timeout with %0d tokens outstanding", token_q.size());
            $display("source_token_scanner verification failed");
            $finish;
        end
    end

    initial begin
        int n_random;
        aresetn  = 0;
        s_tvalid = 0;
        s_tdata  = '0;
        s_tlast  = 0;
        m_tready = 0;
        scanner_clear();

        // directed: number then dot, lone slash, a relational pair, brace span,
        // tab, stray bytes, then the four-results case at source end
        push_text("1.x/a!=\"{\"}\n\"\t");
        push_byte(8'h00);
        push_byte(8'hff);
        push_text("@//c\n1.(");
        end_source();
        push_text("\"ab");
        end_source();

        n_random = 0;
        while (n_random < 180) begin
            n_random = source_q.size();
            push_fragment();
            if ($urandom_range(0, 11) == 0) end_source();
        end
        end_source();

        repeat (8) @(posedge aclk);
        aresetn <= 1;

        while (source_q.size() > 40) @(posedge aclk);
        quiet_tail = 1;
        while (source_q.size() != 0 || s_tvalid || token_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("%0d bytes in %0d sources scanned, %0d tokens checked", bytes_sent,
                 sources_done, tokens_seen);
        $display("keywords, numbers, operators, comments, strings and error bytes mixed in");
        if (mismatches == 0 && token_q.size() == 0) begin
            $display("source_token_scanner verification clean");
        end else begin
            $display("source_token_scanner verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
